### rtl/tarmf_pkg.sv
// Shared types and constants for the three-axis ring median filter.
// Depends on nothing; used by every module of the block.
`default_nettype none

package tarmf_pkg;

	// Ring window depth and derived widths
	localparam int WINDOW = 8;
	localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);

	// Rank of the lower median, rank 0 being the smallest
	localparam logic [CNT_W-1:0] RANK_K = CNT_W'(WINDOW / 2 - 1);

	// Item kind carried in the mode bit of the input tuser
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	// One stored three-axis sample
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} sample_t;

	// Lane update that travels from the sequencer to the rank units
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} lane_upd_t;

endpackage

`default_nettype wire

### rtl/tarmf_ring.sv
// Ring store of three-axis samples: one synchronous memory, per-entry valid bits
// and the wrapping write index. Depends on tarmf_pkg.
`default_nettype none

module tarmf_ring (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire tarmf_pkg::sample_t         wr_data,
	input  wire logic                       rd_en,
	input  wire logic [tarmf_pkg::IDX_W-1:0] rd_addr,
	output tarmf_pkg::sample_t              rd_data
);

	tarmf_pkg::sample_t                  mem [tarmf_pkg::WINDOW];
	logic [tarmf_pkg::WINDOW-1:0]        valid_q;
	logic [tarmf_pkg::IDX_W-1:0]         wr_idx_q;
	tarmf_pkg::sample_t                  rd_data_q;
	logic                                rd_valid_q;

	// Write the sample array and read one entry a cycle while rd_en is set
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Track written entries and advance the write index with wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			wr_idx_q   <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx_q] <= 1'b1;
				if (wr_idx_q == tarmf_pkg::IDX_W'(tarmf_pkg::WINDOW - 1)) begin
					wr_idx_q <= '0;
				end else begin
					wr_idx_q <= wr_idx_q + 1'b1;
				end
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// An entry never written reads as its reset value of zero
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

### rtl/tarmf_rank.sv
// Rank unit for one axis: lanes take the window one entry a cycle while upd.vld is set and
// keep less and equal counts; the lane holding the lower median is picked. Depends on tarmf_pkg.
`default_nettype none

module tarmf_rank (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tarmf_pkg::lane_upd_t  upd,
	input  wire logic signed [15:0]    data,
	output logic signed [15:0]         median
);

	logic signed [15:0]              val_q  [tarmf_pkg::WINDOW];
	logic [tarmf_pkg::CNT_W-1:0]     less_q [tarmf_pkg::WINDOW];
	logic [tarmf_pkg::CNT_W-1:0]     eq_q   [tarmf_pkg::WINDOW];
	logic [tarmf_pkg::WINDOW-1:0]    earlier;
	logic [tarmf_pkg::WINDOW-1:0]    lane_lt;
	logic [tarmf_pkg::WINDOW-1:0]    lane_eq;
	logic [tarmf_pkg::CNT_W-1:0]     new_less;
	logic [tarmf_pkg::CNT_W-1:0]     new_eq;

	// Compare the arriving entry against every lane loaded before it
	always_comb begin
		new_less = '0;
		new_eq   = tarmf_pkg::CNT_W'(1);
		for (int i = 0; i < tarmf_pkg::WINDOW; i++) begin
			earlier[i] = (tarmf_pkg::IDX_W'(i) < upd.idx);
			lane_lt[i] = (val_q[i] < data);
			lane_eq[i] = (val_q[i] == data);
			new_less   = new_less + tarmf_pkg::CNT_W'(earlier[i] & lane_lt[i]);
			new_eq     = new_eq + tarmf_pkg::CNT_W'(earlier[i] & lane_eq[i]);
		end
	end

	// Load the new lane and update the counts of earlier lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tarmf_pkg::WINDOW; i++) begin
				val_q[i]  <= '0;
				less_q[i] <= '0;
				eq_q[i]   <= '0;
			end
		end else if (upd.vld) begin
			for (int i = 0; i < tarmf_pkg::WINDOW; i++) begin
				if (tarmf_pkg::IDX_W'(i) == upd.idx) begin
					val_q[i]  <= data;
					less_q[i] <= new_less;
					eq_q[i]   <= new_eq;
				end else if (earlier[i]) begin
					less_q[i] <= less_q[i] + tarmf_pkg::CNT_W'(!lane_lt[i] && !lane_eq[i]);
					eq_q[i]   <= eq_q[i] + tarmf_pkg::CNT_W'(lane_eq[i]);
				end
			end
		end
	end

	// Pick the lane whose rank span covers the median rank; all such lanes agree
	always_comb begin
		logic [tarmf_pkg::CNT_W:0] span;
		median = '0;
		for (int i = 0; i < tarmf_pkg::WINDOW; i++) begin
			span = {1'b0, less_q[i]} + {1'b0, eq_q[i]};
			if ((less_q[i] <= tarmf_pkg::RANK_K) && ({1'b0, tarmf_pkg::RANK_K} < span)) begin
				median = median | val_q[i];
			end
		end
	end

endmodule

`default_nettype wire

### rtl/three_axis_ring_median_filter.sv
// Top level of the three-axis ring median filter: stream ports, sequencer,
// output register. Depends on tarmf_pkg, tarmf_ring and tarmf_rank.
//
//   channel   dir  tdata (low bit up)                       tuser
//   s_axis    in   x_high x_low z_high z_low y_high y_low   mode, ready_req
//   m_axis    out  median_x median_y median_z               accepted
//
// A sample transfer is written to the ring at its accepting edge when ready_req is set,
// and its result is registered at that same edge.
// A query reads the ring one entry a cycle through its single read port into the rank
// lanes, then passes a drain step and a finish step before its result is registered.
// Reset clears the ring to zero through per-entry valid bits; no clearing pass.
// One item is in work at a time; an input is taken only when the output register
// is empty or empties at that edge, and a query result stalls in its last step
// until the output register frees.
`default_nettype none

module three_axis_ring_median_filter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // x_high, x_low, z_high, z_low, y_high, y_low
	input  wire logic [1:0]  s_tuser,   // mode, ready_req
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // median_x, median_y, median_z
	output logic [0:0]       m_tuser    // accepted
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [tarmf_pkg::IDX_W-1:0]     scan_idx_q;
	tarmf_pkg::lane_upd_t            upd_s1;
	logic                            m_tvalid_q;
	logic [47:0]                     m_tdata_q;
	logic                            m_accepted_q;
	logic                            out_free;
	logic                            out_load;
	logic                            in_xfer;
	logic                            wr_en;
	tarmf_pkg::sample_t              wr_data;
	tarmf_pkg::sample_t              rd_data;
	logic signed [15:0]              med_x;
	logic signed [15:0]              med_y;
	logic signed [15:0]              med_z;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign in_xfer  = s_tvalid && s_tready;

	// Load the output register on a sample transfer or at the end of a scan
	assign out_load = (in_xfer && (s_tuser[0] == tarmf_pkg::MODE_SAMPLE))
		|| ((state_q == ST_FINISH) && out_free);

	// Assemble big-endian axis words; device byte order is X, Z, Y
	assign wr_en     = in_xfer && (s_tuser[0] == tarmf_pkg::MODE_SAMPLE) && s_tuser[1];
	assign wr_data.x = {s_tdata[7:0],   s_tdata[15:8]};
	assign wr_data.z = {s_tdata[23:16], s_tdata[31:24]};
	assign wr_data.y = {s_tdata[39:32], s_tdata[47:40]};

	tarmf_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rd_en   (state_q == ST_SCAN),
		.rd_addr (scan_idx_q),
		.rd_data (rd_data)
	);

	tarmf_rank u_rank_x (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd_s1),
		.data   (rd_data.x),
		.median (med_x)
	);

	tarmf_rank u_rank_y (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd_s1),
		.data   (rd_data.y),
		.median (med_y)
	);

	tarmf_rank u_rank_z (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd_s1),
		.data   (rd_data.z),
		.median (med_z)
	);

	// Sequence the scan and hold the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_idx_q   <= '0;
			upd_s1       <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_accepted_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					upd_s1.vld <= 1'b0;
					if (in_xfer) begin
						if (s_tuser[0] == tarmf_pkg::MODE_SAMPLE) begin
							m_tdata_q    <= '0;
							m_accepted_q <= s_tuser[1];
						end else begin
							scan_idx_q <= '0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					upd_s1.vld <= 1'b1;
					upd_s1.idx <= scan_idx_q;
					if (scan_idx_q == tarmf_pkg::IDX_W'(tarmf_pkg::WINDOW - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					upd_s1.vld <= 1'b0;
					state_q    <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tdata_q    <= {med_z, med_y, med_x};
						m_accepted_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_accepted_q;

`ifndef NO_ASSERTIONS
	// A sample transfer is answered in the next cycle with its ready flag
	a_sample_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == tarmf_pkg::MODE_SAMPLE)
		|=> m_tvalid && (m_tuser[0] == $past(s_tuser[1])))
		else $error("sample transfer not answered in the next cycle");

	// A query transfer starts a scan with the output register empty
	a_query_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] != tarmf_pkg::MODE_SAMPLE)
		|=> (state_q == ST_SCAN) && !m_tvalid && (scan_idx_q == '0))
		else $error("query transfer did not start a clean scan");

	// Lane updates occur only while ring data is arriving
	a_lane_window: assert property (@(posedge clk) disable iff (!arst_n)
		upd_s1.vld |-> ((state_q == ST_SCAN) || (state_q == ST_DRAIN)))
		else $error("lane update outside of a scan");
`endif

endmodule

`default_nettype wire
